### hw/rtl/text_to_glyph_columns_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph column generator
// Concurrent checks clocked on clk_i, with or without the reset guard.
// ---------------------------------------------------------------------------
`ifndef TEXT_TO_GLYPH_COLUMNS_DEFINES_SVH
`define TEXT_TO_GLYPH_COLUMNS_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property outside reset.
`define TGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TGC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TGC_ASSERT(lbl, prop, msg)
`define TGC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### hw/rtl/tgc_pkg.sv
// ---------------------------------------------------------------------------
// tgc_pkg
// Widths, queue item type and the 5-row glyph ROM of the column generator.
// ---------------------------------------------------------------------------
package tgc_pkg;

  localparam int GLYPH_MAX_COLS = 5;
  localparam int CHAR_W         = 8;
  localparam int COL_W          = 5;
  localparam int POS_W          = 12;
  localparam int CNT_W          = 13;
  localparam int WIDTH_W        = $clog2(GLYPH_MAX_COLS + 1);
  localparam int IDX_W          = $clog2(GLYPH_MAX_COLS);
  localparam int SKIP_MARGIN    = 7;
  localparam int LIMIT_RESET    = 512;
  localparam int OUT_DATA_W     = 24;

  typedef struct packed {
    logic [WIDTH_W-1:0]                   width;
    logic [GLYPH_MAX_COLS-1:0][COL_W-1:0] cols;
  } glyph_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic   nul;
    logic   start;
    glyph_t glyph;
  } item_t;

  function automatic glyph_t mk(input int w, input logic [COL_W-1:0] c0,
                                input logic [COL_W-1:0] c1, input logic [COL_W-1:0] c2,
                                input logic [COL_W-1:0] c3, input logic [COL_W-1:0] c4);
    glyph_t g;
    g         = '0;
    g.width   = WIDTH_W'(w);
    g.cols[0] = c0;
    g.cols[1] = c1;
    g.cols[2] = c2;
    g.cols[3] = c3;
    g.cols[4] = c4;
    return g;
  endfunction

  // Fold lower case, then look up; anything unknown maps to the space glyph.
  function automatic glyph_t glyph_lookup(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] up;
    glyph_t            g;
    up = code;
    if (code >= "a" && code <= "z") begin
      up = code - CHAR_W'(32);
    end
    unique case (up)
      "A":     g = mk(4, 5'h1E, 5'h05, 5'h05, 5'h1E, 5'h00);
      "B":     g = mk(4, 5'h1F, 5'h15, 5'h15, 5'h0A, 5'h00);
      "C":     g = mk(4, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h00);
      "D":     g = mk(4, 5'h1F, 5'h11, 5'h11, 5'h0E, 5'h00);
      "E":     g = mk(4, 5'h1F, 5'h15, 5'h15, 5'h11, 5'h00);
      "F":     g = mk(4, 5'h1F, 5'h05, 5'h05, 5'h01, 5'h00);
      "G":     g = mk(4, 5'h0E, 5'h11, 5'h15, 5'h1D, 5'h00);
      "H":     g = mk(4, 5'h1F, 5'h04, 5'h04, 5'h1F, 5'h00);
      "I":     g = mk(3, 5'h11, 5'h1F, 5'h11, 5'h00, 5'h00);
      "J":     g = mk(4, 5'h09, 5'h11, 5'h11, 5'h0F, 5'h00);
      "K":     g = mk(4, 5'h1F, 5'h04, 5'h0A, 5'h11, 5'h00);
      "L":     g = mk(4, 5'h1F, 5'h10, 5'h10, 5'h10, 5'h00);
      "M":     g = mk(5, 5'h1F, 5'h02, 5'h04, 5'h02, 5'h1F);
      "N":     g = mk(4, 5'h1F, 5'h02, 5'h04, 5'h1F, 5'h00);
      "O":     g = mk(4, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00);
      "P":     g = mk(4, 5'h1F, 5'h05, 5'h05, 5'h02, 5'h00);
      "Q":     g = mk(4, 5'h0E, 5'h11, 5'h09, 5'h16, 5'h00);
      "R":     g = mk(4, 5'h1F, 5'h05, 5'h0D, 5'h12, 5'h00);
      "S":     g = mk(4, 5'h12, 5'h15, 5'h15, 5'h09, 5'h00);
      "T":     g = mk(3, 5'h01, 5'h1F, 5'h01, 5'h00, 5'h00);
      "U":     g = mk(4, 5'h0F, 5'h10, 5'h10, 5'h0F, 5'h00);
      "V":     g = mk(5, 5'h07, 5'h08, 5'h10, 5'h08, 5'h07);
      "W":     g = mk(5, 5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F);
      "X":     g = mk(4, 5'h1B, 5'h04, 5'h04, 5'h1B, 5'h00);
      "Y":     g = mk(4, 5'h03, 5'h1C, 5'h1C, 5'h03, 5'h00);
      "Z":     g = mk(4, 5'h19, 5'h15, 5'h15, 5'h13, 5'h00);
      "0":     g = mk(4, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00);
      "1":     g = mk(3, 5'h12, 5'h1F, 5'h10, 5'h00, 5'h00);
      "2":     g = mk(4, 5'h12, 5'h19, 5'h15, 5'h12, 5'h00);
      "3":     g = mk(4, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h00);
      "4":     g = mk(4, 5'h07, 5'h04, 5'h04, 5'h1F, 5'h00);
      "5":     g = mk(4, 5'h17, 5'h15, 5'h15, 5'h09, 5'h00);
      "6":     g = mk(4, 5'h0E, 5'h15, 5'h15, 5'h09, 5'h00);
      "7":     g = mk(4, 5'h11, 5'h09, 5'h05, 5'h03, 5'h00);
      "8":     g = mk(4, 5'h0A, 5'h15, 5'h15, 5'h0A, 5'h00);
      "9":     g = mk(4, 5'h02, 5'h15, 5'h15, 5'h0E, 5'h00);
      "!":     g = mk(1, 5'h17, 5'h00, 5'h00, 5'h00, 5'h00);
      "?":     g = mk(4, 5'h02, 5'h01, 5'h15, 5'h02, 5'h00);
      ".":     g = mk(2, 5'h10, 5'h10, 5'h00, 5'h00, 5'h00);
      "-":     g = mk(3, 5'h04, 5'h04, 5'h04, 5'h00, 5'h00);
      "/":     g = mk(3, 5'h18, 5'h04, 5'h03, 5'h00, 5'h00);
      ":":     g = mk(1, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00);
      default: g = mk(3, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/tgc_fifo.sv
// ---------------------------------------------------------------------------
// tgc_fifo
// Two-entry queue of classified characters between front and back.
// ---------------------------------------------------------------------------
module tgc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  tgc_pkg::item_t wr_item_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output tgc_pkg::item_t rd_item_o
);

  tgc_pkg::item_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push;
  logic           pop;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

### hw/rtl/tgc_front.sv
// ---------------------------------------------------------------------------
// tgc_front
// Accept characters, fold case, look up the glyph and register the result.
// ---------------------------------------------------------------------------
module tgc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tgc_pkg::CHAR_W-1:0]  char_code_i,
  input  logic                        starts_string_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tgc_pkg::item_t              out_item_o
);

  logic           vld_q;
  tgc_pkg::item_t item_q;
  logic           take;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.nul   <= (char_code_i == '0);
      item_q.start <= starts_string_i;
      item_q.glyph <= tgc_pkg::glyph_lookup(char_code_i);
    end
  end

endmodule

### hw/rtl/tgc_back.sv
// ---------------------------------------------------------------------------
// tgc_back
// Keep the column count, decide skip and emit glyph and gap columns.
// ---------------------------------------------------------------------------
`include "text_to_glyph_columns_defines.svh"

module tgc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tgc_pkg::CNT_W-1:0]   limit_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  tgc_pkg::item_t              q_item_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [tgc_pkg::COL_W-1:0]   m_bits_o,
  output logic [tgc_pkg::POS_W-1:0]   m_pos_o,
  output logic                        m_last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                        state_q;
  logic [tgc_pkg::CNT_W-1:0]     cnt_q;
  logic [tgc_pkg::WIDTH_W-1:0]   col_idx_q;
  tgc_pkg::glyph_t               glyph_q;
  logic                          m_valid_q;
  logic [tgc_pkg::COL_W-1:0]     m_bits_q;
  logic [tgc_pkg::POS_W-1:0]     m_pos_q;
  logic                          m_last_q;

  logic [tgc_pkg::CNT_W-1:0]     cnt_eff;
  logic                          skip;
  logic                          out_free;
  logic                          pop;
  logic                          emit;
  logic                          gap;
  logic                          pos_ok;

  always_comb begin
    cnt_eff  = q_item_i.start ? '0 : cnt_q;
    // Signed compare count >= limit - 7, done without a sign bit.
    skip     = ({1'b0, cnt_eff} + (tgc_pkg::CNT_W + 1)'(tgc_pkg::SKIP_MARGIN))
               >= {1'b0, limit_i};
    out_free = !m_valid_q || m_ready_i;
    pop      = (state_q == ST_IDLE) && q_valid_i;
    emit     = (state_q == ST_EMIT) && out_free;
    gap      = (col_idx_q >= glyph_q.width);
    pos_ok   = ({1'b0, cnt_q} + (tgc_pkg::CNT_W + 1)'(1)) < {1'b0, limit_i};
  end

  assign q_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign m_bits_o  = m_bits_q;
  assign m_pos_o   = m_pos_q;
  assign m_last_o  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      col_idx_q <= '0;
      glyph_q   <= '0;
      m_valid_q <= 1'b0;
      m_bits_q  <= '0;
      m_pos_q   <= '0;
      m_last_q  <= 1'b0;
    end else begin
      // Load a new column or drop the one just taken.
      if (out_free) begin
        m_valid_q <= emit;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            cnt_q <= cnt_eff;
            if (!q_item_i.nul && !skip) begin
              state_q   <= ST_EMIT;
              glyph_q   <= q_item_i.glyph;
              col_idx_q <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (emit) begin
            m_bits_q  <= gap ? '0 : glyph_q.cols[col_idx_q[tgc_pkg::IDX_W-1:0]];
            m_pos_q   <= cnt_q[tgc_pkg::POS_W-1:0];
            m_last_q  <= gap;
            cnt_q     <= cnt_q + tgc_pkg::CNT_W'(1);
            col_idx_q <= col_idx_q + tgc_pkg::WIDTH_W'(1);
            if (gap) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TGC_ASSERT(a_idx_in_range, state_q == ST_EMIT |-> col_idx_q <= glyph_q.width, "column index past glyph width")
  `TGC_ASSERT(a_gap_ends_char, emit && gap |=> state_q == ST_IDLE, "gap column did not end the character")
  `TGC_ASSERT(a_skip_drops, pop && (skip || q_item_i.nul) |=> state_q == ST_IDLE, "skipped character started emitting")
  `TGC_ASSERT(a_pos_in_buffer, emit |-> pos_ok, "column emitted at or past the buffer limit")
  `TGC_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == ST_IDLE && !m_valid_q, "not idle after reset")

endmodule

### hw/rtl/text_to_glyph_columns.sv
// An accepted character reaches its first column through the front register, the queue and the back emitter.
// Throughput: one column per cycle while the receiver is ready; the back emitter loads a character, then
// emits its glyph columns and one gap column; NUL and skipped characters are only loaded.
// The two-entry queue lets new characters be accepted while the back emitter is busy.
// Reset (async, active low) clears the column count, the queue and the output valid;
// buffer_limit returns to 512.
// ---------------------------------------------------------------------------
// text_to_glyph_columns
// Character generator for a 5-row bitmap font: one item in, glyph columns out.
// ---------------------------------------------------------------------------
module text_to_glyph_columns (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: buffer_limit
  input  logic                          cfg_we_i,
  input  logic [tgc_pkg::CNT_W-1:0]     cfg_wdata_i,
  // Character stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
  input  logic                          s_axis_tuser,   // [0] starts_string
  // Column stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tgc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [4:0] column_bits,
                                                        // [16:5] column_position, rest zero
  output logic                          m_axis_tlast    // last_of_char
);

  logic [tgc_pkg::CNT_W-1:0] limit_q;

  logic           fr_valid;
  logic           fr_ready;
  tgc_pkg::item_t fr_item;
  logic           q_valid;
  logic           q_ready;
  tgc_pkg::item_t q_item;

  logic [tgc_pkg::COL_W-1:0] col_bits;
  logic [tgc_pkg::POS_W-1:0] col_pos;

  // Hold the buffer limit; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tgc_pkg::CNT_W'(tgc_pkg::LIMIT_RESET);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Front: fold case, look up the glyph, flag NUL and string start.
  tgc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .char_code_i     (s_axis_tdata),
    .starts_string_i (s_axis_tuser),
    .out_valid_o     (fr_valid),
    .out_ready_i     (fr_ready),
    .out_item_o      (fr_item)
  );

  // Queue: decouple the front from the column emitter.
  tgc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // Back: advance the column count, drop or emit, one column per cycle while the receiver is ready.
  tgc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .limit_i   (limit_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_bits_o  (col_bits),
    .m_pos_o   (col_pos),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(tgc_pkg::OUT_DATA_W - tgc_pkg::POS_W - tgc_pkg::COL_W)'(0),
                         col_pos, col_bits};

endmodule

### bench/text_to_glyph_columns_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_to_glyph_columns_tb
// Self-checking bench for the 5-row glyph column generator. A directed table
// covers folding, unknown bytes, NUL handling and the buffer limit extremes.
// Random strings under several limits follow. Every column that comes out is
// compared with the columns of a local font model or of a typed table row.
// ---------------------------------------------------------------------------
module text_to_glyph_columns_tb;

  localparam int CNT_W       = tgc_pkg::CNT_W;
  localparam int POS_W       = tgc_pkg::POS_W;
  localparam int COL_W       = tgc_pkg::COL_W;
  localparam int OUT_DATA_W  = tgc_pkg::OUT_DATA_W;
  localparam int SKIP_MARGIN = tgc_pkg::SKIP_MARGIN;

  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam int         SETTLE_CYCLES = 20;        // room for the queue, the load and the widest glyph
  // Slowest correct run: ~500 items, each with the longest sender gap, its time in the block and
  // six columns that each wait out the longest receiver stall. Allow ~6x.
  localparam int         TIMEOUT_NS    = 800_000;
  localparam int         NUM_PHASES    = 8;

  // All 43 characters of the font string (those with a glyph of their own, and space), for random picks.
  localparam logic [42:0][7:0] FONT_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 !?.-/:";

  typedef enum logic [0:0] {ROW_CHAR, ROW_LIMIT} row_kind_e;
  typedef enum int unsigned {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_mode_e;

  typedef struct packed {
    logic [2:0]             width;
    logic [0:4][COL_W-1:0]  col;        // col[0] is the leftmost column
  } font_glyph_t;

  typedef struct packed {
    logic [COL_W-1:0] bits;
    logic [POS_W-1:0] pos;
    logic             last;
  } column_t;

  // One row of the directed table. A typed row carries its own expectation:
  // either no columns at all, or `width` columns of `bits` from `pos`, then the gap.
  typedef struct packed {
    row_kind_e        kind;
    logic [CNT_W-1:0] value;            // character byte or new buffer limit
    logic             start;
    logic             typed;
    logic             silent;
    logic [2:0]       width;
    logic [COL_W-1:0] bits;
    logic [POS_W-1:0] pos;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Font model state and the columns still owed by the block.
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] limit_reg;
  column_t          expected_cols[$];
  column_t          want;

  idle_mode_e  src_mode  = IDLE_RANDOM;
  idle_mode_e  sink_mode = IDLE_RANDOM;
  int unsigned sink_hold = 0;
  int unsigned fail_count = 0;
  int unsigned drawn_chars;             // characters of this phase that gave columns
  int unsigned phase_chars;             // characters accepted in this phase

  text_to_glyph_columns i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int unsigned draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      default:     return $urandom_range(0, 17);
    endcase
  endfunction

  // Fold lower case, then look up; unknown bytes get the blank space glyph.
  function automatic font_glyph_t font_lookup(input logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch - 8'd32;
    end
    case (up)
      "A":     return {3'd4, 5'h1E, 5'h05, 5'h05, 5'h1E, 5'h00};
      "B":     return {3'd4, 5'h1F, 5'h15, 5'h15, 5'h0A, 5'h00};
      "C":     return {3'd4, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h00};
      "D":     return {3'd4, 5'h1F, 5'h11, 5'h11, 5'h0E, 5'h00};
      "E":     return {3'd4, 5'h1F, 5'h15, 5'h15, 5'h11, 5'h00};
      "F":     return {3'd4, 5'h1F, 5'h05, 5'h05, 5'h01, 5'h00};
      "G":     return {3'd4, 5'h0E, 5'h11, 5'h15, 5'h1D, 5'h00};
      "H":     return {3'd4, 5'h1F, 5'h04, 5'h04, 5'h1F, 5'h00};
      "I":     return {3'd3, 5'h11, 5'h1F, 5'h11, 5'h00, 5'h00};
      "J":     return {3'd4, 5'h09, 5'h11, 5'h11, 5'h0F, 5'h00};
      "K":     return {3'd4, 5'h1F, 5'h04, 5'h0A, 5'h11, 5'h00};
      "L":     return {3'd4, 5'h1F, 5'h10, 5'h10, 5'h10, 5'h00};
      "M":     return {3'd5, 5'h1F, 5'h02, 5'h04, 5'h02, 5'h1F};
      "N":     return {3'd4, 5'h1F, 5'h02, 5'h04, 5'h1F, 5'h00};
      "O":     return {3'd4, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00};
      "P":     return {3'd4, 5'h1F, 5'h05, 5'h05, 5'h02, 5'h00};
      "Q":     return {3'd4, 5'h0E, 5'h11, 5'h09, 5'h16, 5'h00};
      "R":     return {3'd4, 5'h1F, 5'h05, 5'h0D, 5'h12, 5'h00};
      "S":     return {3'd4, 5'h12, 5'h15, 5'h15, 5'h09, 5'h00};
      "T":     return {3'd3, 5'h01, 5'h1F, 5'h01, 5'h00, 5'h00};
      "U":     return {3'd4, 5'h0F, 5'h10, 5'h10, 5'h0F, 5'h00};
      "V":     return {3'd5, 5'h07, 5'h08, 5'h10, 5'h08, 5'h07};
      "W":     return {3'd5, 5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F};
      "X":     return {3'd4, 5'h1B, 5'h04, 5'h04, 5'h1B, 5'h00};
      "Y":     return {3'd4, 5'h03, 5'h1C, 5'h1C, 5'h03, 5'h00};
      "Z":     return {3'd4, 5'h19, 5'h15, 5'h15, 5'h13, 5'h00};
      "0":     return {3'd4, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00};
      "1":     return {3'd3, 5'h12, 5'h1F, 5'h10, 5'h00, 5'h00};
      "2":     return {3'd4, 5'h12, 5'h19, 5'h15, 5'h12, 5'h00};
      "3":     return {3'd4, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h00};
      "4":     return {3'd4, 5'h07, 5'h04, 5'h04, 5'h1F, 5'h00};
      "5":     return {3'd4, 5'h17, 5'h15, 5'h15, 5'h09, 5'h00};
      "6":     return {3'd4, 5'h0E, 5'h15, 5'h15, 5'h09, 5'h00};
      "7":     return {3'd4, 5'h11, 5'h09, 5'h05, 5'h03, 5'h00};
      "8":     return {3'd4, 5'h0A, 5'h15, 5'h15, 5'h0A, 5'h00};
      "9":     return {3'd4, 5'h02, 5'h15, 5'h15, 5'h0E, 5'h00};
      "!":     return {3'd1, 5'h17, 5'h00, 5'h00, 5'h00, 5'h00};
      "?":     return {3'd4, 5'h02, 5'h01, 5'h15, 5'h02, 5'h00};
      ".":     return {3'd2, 5'h10, 5'h10, 5'h00, 5'h00, 5'h00};
      "-":     return {3'd3, 5'h04, 5'h04, 5'h04, 5'h00, 5'h00};
      "/":     return {3'd3, 5'h18, 5'h04, 5'h03, 5'h00, 5'h00};
      ":":     return {3'd1, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00};
      default: return {3'd3, 25'h0};
    endcase
  endfunction

  // Advance the column count for one character and, if asked, queue its columns.
  // Returns how many columns the character gives.
  function automatic int unsigned render_char(input logic [7:0] ch, input logic start,
                                              input logic emit);
    font_glyph_t g;
    int unsigned c;
    int unsigned n;
    n = 0;
    if (start) begin
      col_count = '0;
    end
    // NUL ends the string; past the skip margin the character is dropped whole.
    if (ch == CHAR_NUL) return 0;
    if (int'(col_count) >= int'(limit_reg) - SKIP_MARGIN) return 0;
    g = font_lookup(ch);
    for (c = 0; c < g.width && int'(col_count) < int'(limit_reg) - 1; c++) begin
      if (emit) expected_cols.push_back({g.col[c], col_count[POS_W-1:0], 1'b0});
      col_count = col_count + 1'b1;
      n++;
    end
    // The blank gap column always follows.
    if (emit) expected_cols.push_back({{COL_W{1'b0}}, col_count[POS_W-1:0], 1'b1});
    col_count = col_count + 1'b1;
    return n + 1;
  endfunction

  function automatic stim_row_t row_char(input logic [7:0] ch, input logic start);
    return {ROW_CHAR, {5'd0, ch}, start, 1'b0, 1'b0, 3'd0, {COL_W{1'b0}}, {POS_W{1'b0}}};
  endfunction

  function automatic stim_row_t row_none(input logic [7:0] ch, input logic start);
    return {ROW_CHAR, {5'd0, ch}, start, 1'b1, 1'b1, 3'd0, {COL_W{1'b0}}, {POS_W{1'b0}}};
  endfunction

  function automatic stim_row_t row_cols(input logic [7:0] ch, input logic start,
                                         input logic [2:0] width,
                                         input logic [COL_W-1:0] bits,
                                         input logic [POS_W-1:0] pos);
    return {ROW_CHAR, {5'd0, ch}, start, 1'b1, 1'b0, width, bits, pos};
  endfunction

  function automatic stim_row_t row_limit(input logic [CNT_W-1:0] value);
    return {ROW_LIMIT, value, 1'b0, 1'b0, 1'b0, 3'd0, {COL_W{1'b0}}, {POS_W{1'b0}}};
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0, 1:    ch = 8'($urandom_range(1, 255));       // anything but NUL
      2, 3:    ch = 8'($urandom_range("a", "z"));
      default: ch = FONT_CHARS[$urandom_range(0, 42)];
    endcase
    return ch;
  endfunction

  // Offer one character after the sender's gap and hold it until accepted.
  // Enter and leave at a falling edge; tvalid stays high on the way out.
  task automatic send_char(input logic [7:0] ch, input logic start, input logic emit);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tuser  = start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (render_char(ch, start, emit) != 0) drawn_chars++;
    phase_chars++;
    @(negedge clk_i);
  endtask

  // Drain the block, let any silent characters retire, then write the limit.
  task automatic write_limit(input logic [CNT_W-1:0] value);
    s_axis_tvalid = 1'b0;
    while (expected_cols.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    limit_reg   = value;
  endtask

  // Receiver: hold tready low for the drawn stall after every column.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold != 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare every accepted column with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_cols.size() == 0) begin
        $error("unexpected column: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_cols.pop_front();
        if (m_axis_tdata[COL_W-1:0] !== want.bits) begin
          $error("column_bits: expected %h, got %h", want.bits, m_axis_tdata[COL_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[COL_W+POS_W-1:COL_W] !== want.pos) begin
          $error("column_position: expected %0d, got %0d", want.pos,
                 m_axis_tdata[COL_W+POS_W-1:COL_W]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_char: expected %b, got %b", want.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[OUT_DATA_W-1:COL_W+POS_W] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_axis_tdata[OUT_DATA_W-1:COL_W+POS_W]);
          fail_count++;
        end
      end
      sink_hold = draw_gap(sink_mode);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t        dir_rows[$];
    stim_row_t        r;
    logic [CNT_W-1:0] phase_limits[NUM_PHASES];
    int unsigned      k;
    int unsigned      len;
    int unsigned      cap;

    col_count = '0;
    limit_reg = 13'd512;                  // reset value of buffer_limit

    // Directed table. Positions in typed rows follow from the glyph widths.
    dir_rows.push_back(row_char("A", 1'b1));                    // columns 0..4
    dir_rows.push_back(row_cols("!", 1'b0, 3'd1, 5'h17, 12'd5));
    dir_rows.push_back(row_char("m", 1'b0));                    // fold, widest glyph
    dir_rows.push_back(row_char("z", 1'b0));                    // fold, last letter
    dir_rows.push_back(row_cols(8'hFF, 1'b0, 3'd3, 5'h00, 12'd18)); // unknown -> space
    dir_rows.push_back(row_cols(8'h80, 1'b0, 3'd3, 5'h00, 12'd22));
    dir_rows.push_back(row_cols(8'h01, 1'b0, 3'd3, 5'h00, 12'd26)); // control code
    dir_rows.push_back(row_none(CHAR_NUL, 1'b0));
    dir_rows.push_back(row_cols(":", 1'b0, 3'd1, 5'h0A, 12'd30));   // count kept past NUL
    dir_rows.push_back(row_cols(".", 1'b1, 3'd2, 5'h10, 12'd0));    // new string
    dir_rows.push_back(row_cols("-", 1'b0, 3'd3, 5'h04, 12'd3));
    dir_rows.push_back(row_char("W", 1'b0));
    dir_rows.push_back(row_char("V", 1'b0));
    dir_rows.push_back(row_char("?", 1'b0));
    dir_rows.push_back(row_char("9", 1'b0));
    dir_rows.push_back(row_char(8'h60, 1'b0));                  // just below 'a'
    dir_rows.push_back(row_char("{", 1'b0));                    // just above 'z'
    dir_rows.push_back(row_char(8'h7F, 1'b0));
    dir_rows.push_back(row_none(CHAR_NUL, 1'b1));
    dir_rows.push_back(row_limit(13'd4096));
    dir_rows.push_back(row_char("I", 1'b0));
    dir_rows.push_back(row_limit(13'd7));                       // too small: skip all
    dir_rows.push_back(row_none("T", 1'b1));
    dir_rows.push_back(row_limit(13'd0));
    dir_rows.push_back(row_none("H", 1'b1));
    dir_rows.push_back(row_limit(13'd8));
    dir_rows.push_back(row_char("M", 1'b1));
    dir_rows.push_back(row_none(" ", 1'b0));                    // past the skip margin
    dir_rows.push_back(row_limit(13'd9));
    dir_rows.push_back(row_cols("!", 1'b1, 3'd1, 5'h17, 12'd0));
    dir_rows.push_back(row_none("!", 1'b0));

    // Hold reset, then release it on a falling edge.
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_LIMIT) begin
        write_limit(r.value);
      end else if (!r.typed) begin
        send_char(r.value[7:0], r.start, 1'b1);
      end else begin
        // Typed rows keep the model's count in step but use their own columns.
        send_char(r.value[7:0], r.start, 1'b0);
        if (!r.silent) begin
          for (k = 0; k < r.width; k++) begin
            expected_cols.push_back({r.bits, POS_W'(r.pos + k), 1'b0});
          end
          expected_cols.push_back({{COL_W{1'b0}}, POS_W'(r.pos + r.width), 1'b1});
        end
      end
    end

    // Random strings under a spread of limits, skip-all and the largest among them.
    phase_limits[0] = 13'd4096;
    phase_limits[1] = 13'd20;
    phase_limits[2] = 13'd8;
    phase_limits[3] = CNT_W'($urandom_range(0, 7));
    phase_limits[4] = CNT_W'($urandom_range(9, 60));
    phase_limits[5] = CNT_W'($urandom_range(61, 4096));
    phase_limits[6] = 13'd512;
    phase_limits[7] = 13'd14;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limits[p]);
      src_mode    = idle_mode_e'($urandom_range(0, 2));
      sink_mode   = idle_mode_e'($urandom_range(0, 2));
      drawn_chars = 0;
      phase_chars = 0;
      cap         = (phase_limits[p] < 8) ? 16 : 36;
      while (phase_chars < cap && (phase_limits[p] < 8 || drawn_chars < 45)) begin
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed string: start flag on the first byte, usually NUL at the end.
          len = $urandom_range(1, 24);
          for (k = 0; k < len; k++) send_char(pick_char(), k == 0, 1'b1);
          if ($urandom_range(0, 9) < 7) send_char(CHAR_NUL, $urandom_range(0, 7) == 0, 1'b1);
        end else begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
        end
      end
    end

    // Drain, then give stray columns a chance to show up.
    s_axis_tvalid = 1'b0;
    while (expected_cols.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
